>>> hdl/tidmap_pkg.sv
// Shared constants, codes and controller/datapath interface types of the id map.
package tidmap_pkg;

    // Table geometry and field widths.
    localparam int ENTRIES    = 32;
    localparam int ID_BITS    = 16;
    localparam int VALUE_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int ENTRY_W    = ID_BITS + VALUE_BITS + TIME_BITS;
    localparam int STATUS_W   = 3;

    // Value of the age register after reset.
    localparam logic [TIME_BITS-1:0] MAX_AGE_RESET = TIME_BITS'(100);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STALE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRIM    = 3'd4;

    // Transaction mode codes.
    localparam logic MODE_OBSERVE = 1'b0;
    localparam logic MODE_TRIM    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

endpackage

>>> hdl/tidmap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tidmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tidmap_dp.sv
// Datapath of the id map: entry RAM, valid bits, scan evaluation and result registers.
module tidmap_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tidmap_pkg::t_dp_cmd                   i_cmd,
    output tidmap_pkg::t_dp_stat                  o_stat,
    input  logic                                  i_cfg_we,
    input  logic [tidmap_pkg::TIME_BITS-1:0]      i_cfg_wdata,
    input  logic                                  i_mode,
    input  logic [tidmap_pkg::ID_BITS-1:0]        i_source_id,
    input  logic [tidmap_pkg::VALUE_BITS-1:0]     i_value,
    input  logic [tidmap_pkg::TIME_BITS-1:0]      i_stamp,
    output logic                                  o_strobe,
    output logic [tidmap_pkg::STATUS_W-1:0]       o_status,
    output logic [tidmap_pkg::CNT_W-1:0]          o_removed_count,
    output logic [tidmap_pkg::CNT_W-1:0]          o_occupancy
);
    import tidmap_pkg::*;

    // Configuration and captured transaction.
    logic [TIME_BITS-1:0]  r_max_age;
    logic                  r_mode;
    logic [ID_BITS-1:0]    r_id;
    logic [VALUE_BITS-1:0] r_val;
    logic [TIME_BITS-1:0]  r_stamp;
    logic [TIME_BITS-1:0]  r_limit;
    logic                  r_trim_en;

    // Scan pointer and pending read.
    logic [IDX_W-1:0]      r_addr;
    logic                  r_chk;
    logic [IDX_W-1:0]      r_chk_idx;

    // Table state.
    logic [ENTRIES-1:0]    r_valid;
    logic [CNT_W-1:0]      r_occ;

    // Scan findings.
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [TIME_BITS-1:0]  r_hit_time;
    logic                  r_free;
    logic [IDX_W-1:0]      r_free_idx;
    logic [CNT_W-1:0]      r_removed;

    // Result registers.
    logic                  r_strobe;
    logic [STATUS_W-1:0]   r_status;
    logic [CNT_W-1:0]      r_out_removed;
    logic [CNT_W-1:0]      r_out_occ;

    // RAM connections and decoded read entry.
    logic [ENTRY_W-1:0]    rd_data;
    logic [ID_BITS-1:0]    rd_id;
    logic [TIME_BITS-1:0]  rd_time;
    logic                  rd_valid;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    // Commit decisions.
    logic                  do_update;
    logic                  do_insert;
    logic [STATUS_W-1:0]   n_status;
    logic [CNT_W-1:0]      n_occ;

    tidmap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.scan),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_id    = rd_data[ENTRY_W-1 -: ID_BITS];
    assign rd_time  = rd_data[TIME_BITS-1:0];
    assign rd_valid = r_valid[r_chk_idx];

    assign o_stat.scan_last = (r_addr == IDX_W'(ENTRIES - 1));

    // Commit decision for the finished scan.
    always_comb begin
        do_update = 1'b0;
        do_insert = 1'b0;
        n_status  = ST_TRIM;
        n_occ     = r_occ;
        if (r_mode == MODE_TRIM) begin
            n_status = ST_TRIM;
            n_occ    = r_occ - r_removed;
        end else if (r_hit) begin
            do_update = (r_stamp > r_hit_time);
            n_status  = do_update ? ST_UPDATED : ST_STALE;
        end else if (r_free) begin
            do_insert = 1'b1;
            n_status  = ST_INSERT;
            n_occ     = r_occ + CNT_W'(1);
        end else begin
            n_status = ST_FULL;
        end
    end

    // A hit with a newer stamp rewrites its own entry; an insert fills the first free entry.
    assign wr_en   = i_cmd.commit && (do_update || do_insert);
    assign wr_addr = r_hit ? r_hit_idx : r_free_idx;
    assign wr_data = {r_id, r_val, r_stamp};

    // Age register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RESET;
        end else if (i_cfg_we) begin
            r_max_age <= i_cfg_wdata;
        end
    end

    // Capture of the transaction and the trim limit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_id      <= i_source_id;
            r_val     <= i_value;
            r_stamp   <= i_stamp;
            r_limit   <= i_stamp - r_max_age;
            r_trim_en <= (i_stamp >= r_max_age);
        end
    end

    // Scan control: one read per cycle, evaluated the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_chk  <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.scan) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_chk_idx <= r_addr;
        end
    end

    // Per-entry evaluation, valid bits and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_occ     <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_removed <= '0;
        end else begin
            if (i_cmd.load) begin
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
                r_removed <= '0;
            end else if (r_chk) begin
                if (r_mode == MODE_TRIM) begin
                    if (r_trim_en && rd_valid && (rd_time < r_limit)) begin
                        r_valid[r_chk_idx] <= 1'b0;
                        r_removed          <= r_removed + CNT_W'(1);
                    end
                end else begin
                    if (rd_valid && (rd_id == r_id) && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!rd_valid && !r_free) begin
                        r_free <= 1'b1;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_occ <= n_occ;
                if (do_insert) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
        end
    end

    // Index and time of the first hit, index of the first free entry.
    always_ff @(posedge i_clk) begin
        if (r_chk && (r_mode == MODE_OBSERVE)) begin
            if (rd_valid && (rd_id == r_id) && !r_hit) begin
                r_hit_idx  <= r_chk_idx;
                r_hit_time <= rd_time;
            end
            if (!rd_valid && !r_free) begin
                r_free_idx <= r_chk_idx;
            end
        end
    end

    // Result registers, shown for one cycle after commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= n_status;
            r_out_removed <= (r_mode == MODE_TRIM) ? r_removed : '0;
            r_out_occ     <= n_occ;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_removed_count = r_out_removed;
    assign o_occupancy     = r_out_occ;

    // The occupancy counter matches the valid bits whenever a transaction starts.
    a_occ_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> ($countones(r_valid) == 32'(r_occ)))
        else $error("occupancy counter disagrees with valid bits");

    // Occupancy never exceeds the table size.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= ENTRIES)
        else $error("occupancy above table size");

    // Nothing is written into the table while a scan is reading it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> !wr_en)
        else $error("table write during scan");

endmodule

>>> hdl/tidmap_ctrl.sv
// Controller state machine of the id map: accept, scan, drain, commit.
module tidmap_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output tidmap_pkg::t_dp_cmd  o_cmd,
    input  tidmap_pkg::t_dp_stat i_stat
);
    import tidmap_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // A commit always returns to idle.
    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after commit");

    // An accepted transaction always starts a scan.
    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_SCAN))
        else $error("accepted transaction did not start a scan");

    // The scan leaves only after its last read.
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && !i_stat.scan_last) |=> (r_state == S_SCAN))
        else $error("scan ended early");

endmodule

>>> hdl/timestamped_id_map_with_aging_top.sv
// Top level of the timestamped id map with age-based trimming.
//
// A transaction is accepted when start is high while busy is low. Each one
// sweeps the 32-entry table once through the single read port of the entry
// RAM, one entry per cycle, then evaluates the last entry read in the drain
// state and commits in the commit state; busy stays high until the commit.
// The result is registered at the commit and shown on o_strobe for exactly
// one cycle. A new transaction may be started in that same cycle, but not
// before. The receiver cannot stall results. Observe transactions update,
// insert or drop an id; trim transactions clear entries older than the current
// time minus max_age. The max_age register (reset 100) is written through
// i_cfg_we and i_cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.
module timestamped_id_map_with_aging_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [tidmap_pkg::TIME_BITS-1:0]      i_cfg_wdata,
    input  logic                                  i_mode,
    input  logic [tidmap_pkg::ID_BITS-1:0]        i_source_id,
    input  logic [tidmap_pkg::VALUE_BITS-1:0]     i_value,
    input  logic [tidmap_pkg::TIME_BITS-1:0]      i_stamp,
    output logic                                  o_strobe,
    output logic [tidmap_pkg::STATUS_W-1:0]       o_status,
    output logic [tidmap_pkg::CNT_W-1:0]          o_removed_count,
    output logic [tidmap_pkg::CNT_W-1:0]          o_occupancy
);
    import tidmap_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    tidmap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Table and result logic.
    tidmap_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_source_id     (i_source_id),
        .i_value         (i_value),
        .i_stamp         (i_stamp),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_removed_count (o_removed_count),
        .o_occupancy     (o_occupancy)
    );

endmodule
